FILE: hdl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

FILE: hdl/lrg_pkg.sv
// Package for the logistic regression gradient block: sizes, types, sigmoid table.
// No dependencies.
`default_nettype none
package lrg_pkg;
    localparam int MAX_DIM = 16;
    localparam int IDX_W = $clog2(MAX_DIM);
    localparam int CNT_W = $clog2(MAX_DIM + 1);
    localparam logic signed [31:0] ONE_Q16 = 32'sd65536;
    localparam logic [4:0] LEN_RESET = 5'd10;

    localparam logic [2:0] OP_NONE = 3'd0;
    localparam logic [2:0] OP_MAC = 3'd1;
    localparam logic [2:0] OP_GRAD = 3'd2;
    localparam logic [2:0] OP_WUPD = 3'd3;

    typedef struct packed {
        logic [2:0] op;
        logic signed [31:0] data;
        logic [IDX_W-1:0] idx;
        logic store;
    } cell_cmd_t;

    typedef logic [255:0][31:0] sig_table_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    // The quotient is formed by restoring long division at elaboration time.
    function automatic sig_table_t build_sig_table();
        sig_table_t tbl;
        logic [63:0] e;
        logic [63:0] den;
        logic [63:0] num;
        logic [63:0] q;
        logic [63:0] rem;
        tbl = '0;
        e = 64'd1 << 30;
        for (int t = 0; t <= 128; t++)
        begin
            den = (64'd1 << 30) + e;
            num = (64'd1 << 46) + (den >> 1);
            q = '0;
            rem = '0;
            for (int b = 47; b >= 0; b--)
            begin
                rem = {rem[62:0], num[b]};
                if (rem >= den)
                begin
                    rem = rem - den;
                    q[b] = 1'b1;
                end
            end
            if (t <= 127)
                tbl[128 + t] = q[31:0];
            if (t >= 1)
                tbl[128 - t] = ONE_Q16 - $signed(q[31:0]);
            e = (e * 64'd1008687095 + (64'd1 << 29)) >> 30;
        end
        return tbl;
    endfunction

    localparam sig_table_t SIG_TABLE = build_sig_table();
endpackage
`default_nettype wire

FILE: hdl/lrg_cell.sv
// One cell of the row: holds one weight, gradient and buffered feature.
// Depends on lrg_pkg.
`default_nettype none
module lrg_cell
    import lrg_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic [IDX_W-1:0] pos,
    input  cell_cmd_t cmd_in,
    output cell_cmd_t cmd_out,
    output logic signed [31:0] weight,
    output logic signed [31:0] wnew
);
    logic signed [31:0] w_reg, g_reg, f_reg;
    cell_cmd_t cmd_reg;
    logic signed [63:0] prod;

    assign prod = $signed(f_reg) * $signed(cmd_in.data);
    assign wnew = sat32(64'(w_reg) + 64'(g_reg));
    assign weight = w_reg;
    assign cmd_out = cmd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg <= ONE_Q16;
            g_reg <= '0;
            cmd_reg <= '0;
        end
        else
        begin
            cmd_reg <= cmd_in;
            if (cmd_in.op == OP_MAC && cmd_in.store && cmd_in.idx == pos)
                f_reg <= cmd_in.data;
            if (cmd_in.op == OP_GRAD && cmd_in.store)
                g_reg <= sat32(64'(g_reg) + 64'(sat32(prod >>> 16)));
            if (cmd_in.op == OP_WUPD)
            begin
                if (cmd_in.store)
                    w_reg <= wnew;
                g_reg <= '0;
            end
        end
    end
endmodule
`default_nettype wire

FILE: hdl/logistic_regression_gradient.sv
// Top level: control sequencer, dot product, sigmoid and the cell row.
// Depends on lrg_pkg, lrg_cell and assert_macros.svh.
//  channel | valid     | stall     | payload
//  in      | in_valid  | in_stall  | mode feature label
//  out     | out_valid | out_stall | weight_value weight_index last
// The last feature of a sample stalls the input while the sigmoid scale is
// formed and walks the cell row. End of pass stalls while the update walks
// the row, then gives one weight per output transfer. Reset gives weights
// of 1.0 and a zero gradient. Output stall holds the output register.
`default_nettype none
`include "assert_macros.svh"
module logistic_regression_gradient
    import lrg_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cfg_we,
    input  wire logic [4:0] cfg_wdata,
    input  wire logic in_valid,
    output logic in_stall,
    input  wire logic mode,
    input  wire logic signed [31:0] feature,
    input  wire logic label,
    output logic out_valid,
    input  wire logic out_stall,
    output logic signed [31:0] weight_value,
    output logic [3:0] weight_index,
    output logic last
);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SIG = 2'd1;
    localparam logic [1:0] ST_WALK = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0] state_reg;
    logic [4:0] vlen_reg;
    logic [CNT_W-1:0] len, cnt_reg, wait_reg, emit_reg;
    logic signed [47:0] acc_reg;
    logic signed [31:0] scale_reg;
    logic signed [31:0] wsel, wn_sel;
    logic signed [63:0] mprod;
    logic signed [48:0] sum49;
    logic signed [47:0] acc_new;
    logic [IDX_W-1:0] pos;
    logic lbl_reg;
    logic signed [48:0] z;
    logic signed [37:0] zi;
    logic [7:0] sidx;
    logic signed [31:0] sig_val;
    cell_cmd_t head;
    cell_cmd_t chain [MAX_DIM+1];
    logic signed [31:0] wts [MAX_DIM];
    logic signed [31:0] wns [MAX_DIM];
    logic in_ok, out_ok;

    assign len = (vlen_reg == 0) ? CNT_W'(1) :
        (32'(vlen_reg) > MAX_DIM) ? CNT_W'(MAX_DIM) : CNT_W'(vlen_reg);
    assign in_stall = (state_reg != ST_IDLE);
    assign in_ok = in_valid && !in_stall;
    assign out_ok = out_valid && !out_stall;
    assign pos = (cnt_reg >= CNT_W'(MAX_DIM)) ? IDX_W'(MAX_DIM - 1) : cnt_reg[IDX_W-1:0];
    assign wsel = wts[pos];
    assign mprod = $signed(feature) * $signed(wsel);
    assign sum49 = 49'(acc_reg) + 49'(mprod >>> 16);
    assign acc_new = (sum49 > 49'sh7fffffffffff) ? 48'sh7fffffffffff :
        (sum49 < -49'sh800000000000) ? 48'sh800000000000 : sum49[47:0];
    assign z = lbl_reg ? 49'(acc_reg) : -49'(acc_reg);
    assign zi = 38'(z >>> 12) + 38'sd128;
    assign sidx = (zi < 0) ? 8'd0 : (zi > 38'sd255) ? 8'd255 : zi[7:0];
    assign sig_val = SIG_TABLE[sidx];
    assign wn_sel = wns[emit_reg[IDX_W-1:0]];

    always_comb
    begin
        head = '0;
        if (in_ok && !mode)
        begin
            head.store = 1'b1;
            head.idx = pos;
            head.data = feature;
        end
        else if (state_reg == ST_WALK && wait_reg == 0)
        begin
            head.op = OP_GRAD;
            head.data = scale_reg;
        end
        else if (in_ok && mode)
            head.op = OP_WUPD;
    end

    assign chain[0] = head;
    for (genvar i = 0; i < MAX_DIM; i++)
    begin : g_row
        cell_cmd_t ci;
        always_comb
        begin
            ci = chain[i];
            if (ci.op == OP_GRAD || ci.op == OP_WUPD)
            begin
                ci.store = (i < int'(len));
                ci.idx = IDX_W'(i);
            end
            else if (ci.store)
                ci.op = OP_MAC;
        end
        lrg_cell u_cell (
            .clk(clk), .rst_n(rst_n), .pos(IDX_W'(i)), .cmd_in(ci),
            .cmd_out(chain[i+1]), .weight(wts[i]), .wnew(wns[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            vlen_reg <= LEN_RESET;
            cnt_reg <= '0;
            acc_reg <= '0;
            wait_reg <= '0;
            emit_reg <= '0;
            out_valid <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                vlen_reg <= cfg_wdata;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_ok && !mode)
                    begin
                        acc_reg <= acc_new;
                        lbl_reg <= label;
                        if (32'(pos) + 1 >= 32'(len))
                            state_reg <= ST_SIG;
                        else
                            cnt_reg <= CNT_W'(pos) + CNT_W'(1);
                    end
                    else if (in_ok)
                    begin
                        cnt_reg <= '0;
                        acc_reg <= '0;
                        wait_reg <= CNT_W'(MAX_DIM);
                        emit_reg <= '0;
                        state_reg <= ST_EMIT;
                    end
                end
                ST_SIG:
                begin
                    scale_reg <= lbl_reg ? -sig_val : sig_val;
                    cnt_reg <= '0;
                    acc_reg <= '0;
                    wait_reg <= '0;
                    state_reg <= ST_WALK;
                end
                ST_WALK:
                begin
                    if (wait_reg == CNT_W'(MAX_DIM))
                        state_reg <= ST_IDLE;
                    wait_reg <= wait_reg + CNT_W'(1);
                end
                ST_EMIT:
                begin
                    if (wait_reg != 0)
                        wait_reg <= wait_reg - CNT_W'(1);
                    if (out_ok && last)
                    begin
                        out_valid <= 1'b0;
                        state_reg <= ST_IDLE;
                    end
                    else if (!out_valid || out_ok)
                    begin
                        if (out_ok)
                            emit_reg <= emit_reg + CNT_W'(1);
                        if (wait_reg == 0 || out_valid)
                            out_valid <= 1'b1;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // After the weight update the new values sit in the cells; wnew shows
    // weight plus a cleared gradient, which is the stored weight.
    assign weight_value = wts[emit_reg[IDX_W-1:0]] + (wn_sel - wn_sel);
    assign weight_index = 4'(emit_reg);
    assign last = (emit_reg + CNT_W'(1) == len);

    `ASSERT_IMPLIES(a_stall_busy, clk, rst_n, out_valid, state_reg == ST_EMIT)
    `ASSERT_IMPLIES(a_idx_range, clk, rst_n, out_valid, emit_reg < len)
    `ASSERT_NEXT(a_last_done, clk, rst_n, out_ok && last, !out_valid)
endmodule
`default_nettype wire
